@@ hdl/csw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine-sum window package
// Shared types, constants and the quarter-wave cosine table function.
// ----------------------------------------------------------------------------
package csw_pkg;

  // Default table depth and output fraction width.
  localparam int COS_TABLE_DEPTH_DEF = 256;
  localparam int FRACTION_BITS_DEF   = 16;

  // Queue depths on either side of the cosine unit.
  localparam int MID_DEPTH = 32;
  localparam int OUT_DEPTH = 8;

  // pi/2 in Q2.30, used to place the table samples.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_WINDOW_LENGTH = 3'd0,
    REG_COEFF_ZERO    = 3'd1,
    REG_COEFF_ONE     = 3'd2,
    REG_COEFF_TWO     = 3'd3,
    REG_COEFF_THREE   = 3'd4
  } reg_index_t;

  localparam logic [16:0] WINDOW_LENGTH_RST = 17'd1024;
  localparam logic [15:0] COEFF_ZERO_RST    = 16'd23511;
  localparam logic [15:0] COEFF_ONE_RST     = 16'd32001;
  localparam logic [15:0] COEFF_TWO_RST     = 16'd9259;
  localparam logic [15:0] COEFF_THREE_RST   = 16'd765;

  // Item between the phase unit and the cosine unit.
  typedef struct packed {
    logic        err;
    logic [15:0] phase;
  } mid_item_t;

  // Finished result.
  typedef struct packed {
    logic        err;
    logic [16:0] value;
  } out_item_t;

  // Cosine magnitude in Q1.15 of an angle x in Q2.30 radians (Taylor series).
  function automatic logic [15:0] cos_entry(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned scaled;
    begin
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      term = ((term * x2) >> 30) / 2;   sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 12;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 30;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 56;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 90;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 132; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 182; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 240; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 306; sum = sum - longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      scaled = ((longint'(sum) * 64'd32768) + (64'd1 << 29)) >> 30;
      return scaled[15:0];
    end
  endfunction

endpackage

@@ hdl/cosine_sum_window_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine-sum window generator
// Four-term cosine-sum window weight (Blackman-Harris by default) for a sample index.
// ----------------------------------------------------------------------------
// Path: an accepted index passes the entry stage and the 16-stage phase divider,
// the middle queue, the 5 cosine stages and then the result queue.
// Throughput: one index per cycle while results are taken.
// Reset: synchronous; clears the queues and restores the default length and
// coefficients. No clearing pass is needed.
module cosine_sum_window_generator #(
  parameter int COS_TABLE_DEPTH = csw_pkg::COS_TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS   = csw_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] sample_index,
  output logic        empty,
  input  logic        pop,
  output logic [16:0] window_value,
  output logic        index_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [16:0] cfg_data
);

  localparam int MCW = $clog2(csw_pkg::MID_DEPTH + 1);
  localparam int OCW = $clog2(csw_pkg::OUT_DEPTH + 1);

  // Configuration registers.
  logic [16:0] window_length;
  logic [15:0] coeff_zero;
  logic [15:0] coeff_one;
  logic [15:0] coeff_two;
  logic [15:0] coeff_three;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= csw_pkg::WINDOW_LENGTH_RST;
      coeff_zero    <= csw_pkg::COEFF_ZERO_RST;
      coeff_one     <= csw_pkg::COEFF_ONE_RST;
      coeff_two     <= csw_pkg::COEFF_TWO_RST;
      coeff_three   <= csw_pkg::COEFF_THREE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        csw_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data;
        csw_pkg::REG_COEFF_ZERO:    coeff_zero    <= cfg_data[15:0];
        csw_pkg::REG_COEFF_ONE:     coeff_one     <= cfg_data[15:0];
        csw_pkg::REG_COEFF_TWO:     coeff_two     <= cfg_data[15:0];
        csw_pkg::REG_COEFF_THREE:   coeff_three   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Transaction handshakes and credit counters guarding both queues.
  logic           in_acc;
  logic           out_acc;
  logic           mid_take;
  logic           mid_empty;
  logic [MCW-1:0] front_cnt;
  logic [OCW-1:0] back_cnt;

  assign in_acc   = push && !full;
  assign out_acc  = pop && !empty;
  assign mid_take = !mid_empty && (back_cnt < OCW'(csw_pkg::OUT_DEPTH));
  assign full     = (front_cnt == MCW'(csw_pkg::MID_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      front_cnt <= '0;
      back_cnt  <= '0;
    end else begin
      front_cnt <= front_cnt + MCW'(in_acc) - MCW'(mid_take);
      back_cnt  <= back_cnt + OCW'(mid_take) - OCW'(out_acc);
    end
  end

  // Phase unit.
  logic               front_valid;
  csw_pkg::mid_item_t front_item;

  csw_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_acc),
    .in_index      (sample_index),
    .window_length (window_length),
    .out_valid     (front_valid),
    .out_item      (front_item)
  );

  // Queue between the phase unit and the cosine unit.
  csw_pkg::mid_item_t mid_item;

  csw_fifo #(
    .WIDTH ($bits(csw_pkg::mid_item_t)),
    .DEPTH (csw_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_data (front_item),
    .pop       (mid_take),
    .pop_data  (mid_item),
    .empty     (mid_empty)
  );

  // Cosine unit.
  logic               back_valid;
  csw_pkg::out_item_t back_item;

  csw_back #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (mid_take),
    .in_item     (mid_item),
    .coeff_zero  (coeff_zero),
    .coeff_one   (coeff_one),
    .coeff_two   (coeff_two),
    .coeff_three (coeff_three),
    .out_valid   (back_valid),
    .out_item    (back_item)
  );

  // Result queue.
  csw_pkg::out_item_t res_item;

  csw_fifo #(
    .WIDTH ($bits(csw_pkg::out_item_t)),
    .DEPTH (csw_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (back_valid),
    .push_data (back_item),
    .pop       (out_acc),
    .pop_data  (res_item),
    .empty     (empty)
  );

  assign window_value = res_item.value;
  assign index_error  = res_item.err;

  // Credit counters never exceed their queue depths.
  assert property (@(posedge clk) disable iff (rst)
    front_cnt <= MCW'(csw_pkg::MID_DEPTH))
    else $error("front credit count overflow");

  assert property (@(posedge clk) disable iff (rst)
    back_cnt <= OCW'(csw_pkg::OUT_DEPTH))
    else $error("back credit count overflow");

  // An out-of-range result always carries a zero weight.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && index_error) |-> (window_value == '0))
    else $error("error result with non-zero weight");

  // The cosine unit only takes from a non-empty queue.
  assert property (@(posedge clk) disable iff (rst)
    mid_take |-> !mid_empty)
    else $error("read from empty middle queue");

endmodule

@@ hdl/csw_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine-sum window queue
// Small register-based first-in first-out queue; the head is always visible.
// ----------------------------------------------------------------------------
module csw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  // Storage write; the caller guarantees space by credit counting.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop && !empty);
    end
  end

  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

endmodule

@@ hdl/csw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine-sum window phase unit
// Checks the index against the window length and works out the phase
// floor(i * 65536 / N) with a pipelined restoring divider, one bit a stage.
// ----------------------------------------------------------------------------
module csw_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [15:0]        in_index,
  input  logic [16:0]        window_length,
  output logic               out_valid,
  output csw_pkg::mid_item_t out_item
);

  localparam int STAGES = 16;

  logic        valid [STAGES+1];
  logic        err   [STAGES+1];
  logic [16:0] rem   [STAGES+1];
  logic [15:0] quot  [STAGES+1];

  // Entry stage: range check and the initial remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    err[0]  <= ({1'b0, in_index} >= window_length);
    rem[0]  <= {1'b0, in_index};
    quot[0] <= '0;
  end

  // Divider stages: each shifts the remainder and yields one quotient bit.
  for (genvar s = 1; s <= STAGES; s++) begin : g_div
    logic [17:0] rem2;
    logic        ge;
    logic [17:0] diff;

    assign rem2 = {rem[s-1], 1'b0};
    assign ge   = (rem2 >= {1'b0, window_length});
    assign diff = rem2 - {1'b0, window_length};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else begin
        valid[s] <= valid[s-1];
      end
    end

    always_ff @(posedge clk) begin
      err[s]  <= err[s-1];
      rem[s]  <= ge ? diff[16:0] : rem2[16:0];
      quot[s] <= {quot[s-1][14:0], ge};
    end
  end

  assign out_valid      = valid[STAGES];
  assign out_item.err   = err[STAGES];
  assign out_item.phase = quot[STAGES];

endmodule

@@ hdl/csw_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine-sum window cosine unit
// Looks up three harmonic cosines with interpolation, weights them and forms
// the rounded, clamped window value over five pipeline stages.
// ----------------------------------------------------------------------------
module csw_back #(
  parameter int COS_TABLE_DEPTH = csw_pkg::COS_TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS   = csw_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  csw_pkg::mid_item_t in_item,
  input  logic [15:0]        coeff_zero,
  input  logic [15:0]        coeff_one,
  input  logic [15:0]        coeff_two,
  input  logic [15:0]        coeff_three,
  output logic               out_valid,
  output csw_pkg::out_item_t out_item
);

  localparam int PW = 15 + $clog2(COS_TABLE_DEPTH + 1);
  localparam int IW = PW - 14;
  localparam int TW = $clog2(COS_TABLE_DEPTH + 2);
  localparam int SH = 31 - FRACTION_BITS;
  localparam logic [35:0] RND   = 36'd1 << (SH - 1);
  localparam logic [35:0] ONE_V = 36'd1 << FRACTION_BITS;

  // Constant quarter-wave table; the two entries past the end are zero.
  logic [15:0] tbl [COS_TABLE_DEPTH+2];
  for (genvar g = 0; g < COS_TABLE_DEPTH + 2; g++) begin : g_tbl
    localparam longint unsigned X = (csw_pkg::HALF_PI_Q30 * g) / COS_TABLE_DEPTH;
    if (g < COS_TABLE_DEPTH) begin : g_val
      assign tbl[g] = csw_pkg::cos_entry(X);
    end else begin : g_zero
      assign tbl[g] = '0;
    end
  end

  logic [4:0] valid;
  logic [4:0] err;

  // Valid and error flags travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    err <= {err[3:0], in_item.err};
  end

  // Harmonic phases.
  logic [15:0] phase [3];
  assign phase[0] = in_item.phase;
  assign phase[1] = {in_item.phase[14:0], 1'b0};
  assign phase[2] = in_item.phase + {in_item.phase[14:0], 1'b0};

  logic [15:0]        coeff [3];
  assign coeff[0] = coeff_one;
  assign coeff[1] = coeff_two;
  assign coeff[2] = coeff_three;

  logic signed [33:0] prod [3];

  for (genvar h = 0; h < 3; h++) begin : g_harm
    logic [1:0]         quad;
    logic [13:0]        w;
    logic [14:0]        u;
    logic [PW-1:0]      pos;
    logic               neg1;
    logic [TW-1:0]      idx;
    logic               zero2;
    logic               neg2;
    logic [15:0]        lo2;
    logic [15:0]        d2;
    logic [13:0]        frac2;
    logic [30:0]        interp;
    logic [15:0]        mag;
    logic signed [16:0] cosv;

    // Stage one: fold into the first quadrant and scale to table units.
    assign quad = phase[h][15:14];
    assign w    = phase[h][13:0];
    assign u    = quad[0] ? (15'd16384 - {1'b0, w}) : {1'b0, w};

    always_ff @(posedge clk) begin
      pos  <= PW'(u) * PW'(COS_TABLE_DEPTH);
      neg1 <= (quad == 2'd1) || (quad == 2'd2);
    end

    // Stage two: table read of both neighbours.
    assign idx = pos[14 +: TW];

    always_ff @(posedge clk) begin
      zero2 <= (pos[PW-1:14] >= IW'(COS_TABLE_DEPTH));
      neg2  <= neg1;
      lo2   <= tbl[idx];
      d2    <= (tbl[idx] > tbl[idx + 1'b1]) ? (tbl[idx] - tbl[idx + 1'b1]) : '0;
      frac2 <= pos[13:0];
    end

    // Stage three: linear interpolation and sign.
    assign interp = (31'(d2) * 31'(frac2)) + 31'd8192;
    assign mag    = zero2 ? '0 : (lo2 - interp[29:14]);

    always_ff @(posedge clk) begin
      cosv <= neg2 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    // Stage four: weighting.
    always_ff @(posedge clk) begin
      prod[h] <= $signed({1'b0, coeff[h]}) * cosv;
    end
  end

  // Constant term, aligned with the products.
  logic [15:0] a0_d1;
  logic [15:0] a0_d2;
  logic [30:0] a0_term;

  always_ff @(posedge clk) begin
    a0_d1   <= coeff_zero;
    a0_d2   <= a0_d1;
    a0_term <= {a0_d2, 15'd0};
  end

  // Stage five: sum of the four terms.
  logic signed [35:0] acc;

  always_ff @(posedge clk) begin
    acc <= $signed({5'd0, a0_term}) - 36'(prod[0]) + 36'(prod[1]) - 36'(prod[2]);
  end

  // Rounding and clamping into the result.
  logic [35:0] rounded;
  logic [35:0] clamped;

  always_comb begin
    rounded = (unsigned'(acc) + RND) >> SH;
    if (acc <= 0) begin
      clamped = '0;
    end else if (rounded > ONE_V) begin
      clamped = ONE_V;
    end else begin
      clamped = rounded;
    end
  end

  assign out_valid      = valid[4];
  assign out_item.err   = err[4];
  assign out_item.value = err[4] ? '0 : clamped[16:0];

endmodule
